>>> design/zero_crossing_edge_detect_core_assert.svh
// Assertion macros shared by the zero-crossing edge detector RTL.
// Depends on nothing; each macro expands to nothing when ASSERT_OFF is set.
`ifndef ZERO_CROSSING_EDGE_DETECT_CORE_ASSERT_SVH
`define ZERO_CROSSING_EDGE_DETECT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define ZCED_ASSERT(label, prop, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("zced assertion failed");
`define ZCED_ASSERT_ALWAYS(label, prop, clk) \
  label: assert property (@(posedge clk) prop) \
    else $error("zced assertion failed");
`else
`define ZCED_ASSERT(label, prop, clk, rst_n)
`define ZCED_ASSERT_ALWAYS(label, prop, clk)
`endif

`endif

>>> design/zced_pkg.sv
// Types and constants of the zero-crossing edge detector.
// Used by the interfaces, the output queue and the top level.
package zced_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 11;
  localparam int THRESH_W   = 17;
  localparam int EDGE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int OUT_DEPTH  = 3;
  localparam int OUT_CNT_W  = 2;

  localparam logic [EDGE_W-1:0]   EDGE_ON      = 8'd255;
  localparam logic [EDGE_W-1:0]   EDGE_OFF     = 8'd0;
  localparam logic [DIM_W-1:0]    DIM_MIN      = 11'd3;
  localparam logic [DIM_W-1:0]    HEIGHT_MAX   = 11'd1024;
  localparam logic [DIM_W-1:0]    WIDTH_RST    = 11'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST   = 11'd480;
  localparam logic [THRESH_W-1:0] THRESH_RST   = 17'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [EDGE_W-1:0]  edge_value;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
  } result_t;

  typedef struct packed {
    logic                 full;
    logic [OUT_CNT_W-1:0] count;
  } queue_status_t;

endpackage

>>> design/zced_ifs.sv
// Valid/ready stream interfaces for the sample input and the result output.
// Depends on zced_pkg for field widths.
interface zced_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [zced_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface zced_result_if;
  logic                          valid;
  logic                          ready;
  logic [zced_pkg::EDGE_W-1:0]   edge_value;
  logic [zced_pkg::COORD_W-1:0]  out_row;
  logic [zced_pkg::COORD_W-1:0]  out_col;

  modport source (output valid, output edge_value, output out_row, output out_col,
                  input ready);
  modport sink (input valid, input edge_value, input out_row, input out_col,
                output ready);
endinterface

>>> design/zced_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; a read of the address being written returns the old data.
module zced_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/zced_out_queue.sv
// Three-entry result queue that drives the result stream.
// Depends on zced_pkg and zced_result_if.
module zced_out_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  zced_pkg::result_t       push_data_i,
  output zced_pkg::queue_status_t status_o,
  zced_result_if.source           out_o
);

  localparam logic [zced_pkg::OUT_CNT_W-1:0] LAST = zced_pkg::OUT_CNT_W'(zced_pkg::OUT_DEPTH - 1);
  localparam logic [zced_pkg::OUT_CNT_W-1:0] FULL = zced_pkg::OUT_CNT_W'(zced_pkg::OUT_DEPTH);

  zced_pkg::result_t                 entry_q [zced_pkg::OUT_DEPTH];
  logic [zced_pkg::OUT_CNT_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [zced_pkg::OUT_CNT_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [zced_pkg::OUT_CNT_W-1:0]    count_q, count_d;
  logic                              pop;
  zced_pkg::result_t                 head;

  assign pop  = out_o.valid & out_o.ready;
  assign head = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign out_o.valid      = (count_q != '0);
  assign out_o.edge_value = head.edge_value;
  assign out_o.out_row    = head.out_row;
  assign out_o.out_col    = head.out_col;

  assign status_o.full  = (count_q == FULL);
  assign status_o.count = count_q;

endmodule

>>> design/zero_crossing_edge_detect_core.sv
// Zero-crossing edge detector: line-store RAMs, scoring pipeline and result queue.
// Depends on zced_pkg, zced_ifs, zced_ram, zced_out_queue and the assertion header.
//
// The block takes one Q8.8 Laplacian sample per clock and returns one result per
// sample, sustained at one item per cycle while the output does not stall. A
// result for row r is produced while row r+1 arrives; during row 0 the bottom
// border row of the previous frame is reported with value 0. The line-store RAMs
// are read at the edge that accepts a sample, and the next cycle scores the item,
// writes the shifted line stores back and pushes the result into the queue, so
// the result is offered on the output once the queue has registered it. Input
// ready depends only on how many items sit in the scoring stage and the three-entry
// queue and drops once they hold three, so at full rate a stalled output lets one
// more item in before the input stops. The line stores hold no reset contents and
// need no clearing pass.
`include "zero_crossing_edge_detect_core_assert.svh"

module zero_crossing_edge_detect_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [zced_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [zced_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  zced_sample_if.sink                         in_i,
  zced_result_if.source                       out_o
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [zced_pkg::DIM_W-1:0] WMAX =
    zced_pkg::DIM_W'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);

  function automatic logic [zced_pkg::THRESH_W-1:0] cross_score(
    input logic signed [zced_pkg::SAMPLE_W-1:0] a,
    input logic signed [zced_pkg::SAMPLE_W-1:0] b
  );
    logic signed [zced_pkg::SAMPLE_W:0] ax;
    logic signed [zced_pkg::SAMPLE_W:0] bx;
    logic [zced_pkg::SAMPLE_W:0]        am;
    logic [zced_pkg::SAMPLE_W:0]        bm;
    ax = {a[zced_pkg::SAMPLE_W-1], a};
    bx = {b[zced_pkg::SAMPLE_W-1], b};
    am = (ax < 0) ? -ax : ax;
    bm = (bx < 0) ? -bx : bx;
    if (((ax < 0) && (bx > 0)) || ((ax > 0) && (bx < 0))) begin
      return am + bm;
    end
    return '0;
  endfunction

  logic [zced_pkg::DIM_W-1:0]     width_q, height_q;
  logic [zced_pkg::THRESH_W-1:0]  thresh_q;
  logic [zced_pkg::DIM_W-1:0]     width_eff, height_eff;

  logic [zced_pkg::COORD_W-1:0]   row_q, row_d, col_q, col_d;
  logic [zced_pkg::DIM_W-1:0]     row_ext, col_ext, col_inc, row_inc;
  logic                           in_accept;
  logic [AW-1:0]                  ctr_addr, right_addr;
  logic                           active0;
  logic [zced_pkg::COORD_W-1:0]   orow0;

  logic                           s1_valid_q;
  logic                           s1_active_q;
  logic [zced_pkg::COORD_W-1:0]   s1_row_q, s1_col_q;
  logic [AW-1:0]                  s1_addr_q;
  logic signed [zced_pkg::SAMPLE_W-1:0] s1_below_q;
  logic signed [zced_pkg::SAMPLE_W-1:0] left_q;

  logic [zced_pkg::SAMPLE_W-1:0]  near_ctr_rd, near_right_rd, far_rd;
  logic signed [zced_pkg::SAMPLE_W-1:0] center, right_s, above, ha, va;
  logic [zced_pkg::THRESH_W:0]    total;
  logic                           is_edge;
  zced_pkg::result_t              result;
  zced_pkg::queue_status_t        q_status;
  logic [2:0]                     occupancy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= zced_pkg::WIDTH_RST;
      height_q <= zced_pkg::HEIGHT_RST;
      thresh_q <= zced_pkg::THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (zced_pkg::cfg_idx_e'(cfg_idx_i))
        zced_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[zced_pkg::DIM_W-1:0];
        zced_pkg::CFG_HEIGHT: height_q <= cfg_data_i[zced_pkg::DIM_W-1:0];
        zced_pkg::CFG_THRESH: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < zced_pkg::DIM_MIN) begin
      width_eff = zced_pkg::DIM_MIN;
    end else if (width_q > WMAX) begin
      width_eff = WMAX;
    end else begin
      width_eff = width_q;
    end
    if (height_q < zced_pkg::DIM_MIN) begin
      height_eff = zced_pkg::DIM_MIN;
    end else if (height_q > zced_pkg::HEIGHT_MAX) begin
      height_eff = zced_pkg::HEIGHT_MAX;
    end else begin
      height_eff = height_q;
    end
  end

  // Stage 0: accept, position bookkeeping and line-store reads.
  assign occupancy = {2'b00, s1_valid_q} + {1'b0, q_status.count};
  assign in_i.ready = (occupancy <= 3'd2);
  assign in_accept  = in_i.valid & in_i.ready;

  assign row_ext = {1'b0, row_q};
  assign col_ext = {1'b0, col_q};
  assign col_inc = col_ext + 1'b1;
  assign row_inc = row_ext + 1'b1;

  always_comb begin
    if (int'(col_q) < MAX_WIDTH) begin
      ctr_addr = AW'(col_q);
    end else begin
      ctr_addr = AW'(MAX_WIDTH - 1);
    end
    right_addr = AW'(col_inc);
    active0 = (row_q >= 10'd2) && (row_ext < height_eff) && (col_q >= 10'd1) &&
              (col_inc < width_eff) && (int'(col_inc) < MAX_WIDTH);
    orow0 = (row_q == '0) ? zced_pkg::COORD_W'(height_eff - 1'b1) : row_q - 1'b1;
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (col_inc >= width_eff) begin
      col_d = '0;
      row_d = (row_inc >= height_eff) ? '0 : zced_pkg::COORD_W'(row_inc);
    end else if (row_ext >= height_eff) begin
      row_d = '0;
      col_d = '0;
    end else begin
      col_d = zced_pkg::COORD_W'(col_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
      left_q     <= '0;
    end else begin
      s1_valid_q <= in_accept;
      if (in_accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (s1_valid_q) begin
        left_q <= center;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_active_q <= active0;
      s1_row_q    <= orow0;
      s1_col_q    <= col_q;
      s1_addr_q   <= ctr_addr;
      s1_below_q  <= in_i.sample;
    end
  end

  zced_ram #(.WIDTH(zced_pkg::SAMPLE_W), .DEPTH(MAX_WIDTH)) u_near_ctr (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_below_q),
    .raddr_i (ctr_addr),
    .rdata_o (near_ctr_rd)
  );

  zced_ram #(.WIDTH(zced_pkg::SAMPLE_W), .DEPTH(MAX_WIDTH)) u_near_right (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_below_q),
    .raddr_i (right_addr),
    .rdata_o (near_right_rd)
  );

  zced_ram #(.WIDTH(zced_pkg::SAMPLE_W), .DEPTH(MAX_WIDTH)) u_far (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (center),
    .raddr_i (ctr_addr),
    .rdata_o (far_rd)
  );

  // Stage 1: scoring and write-back of the shifted line stores.
  always_comb begin
    center  = $signed(near_ctr_rd);
    right_s = $signed(near_right_rd);
    above   = $signed(far_rd);
    ha      = (center != '0) ? center : left_q;
    va      = (center != '0) ? center : above;
    total   = {1'b0, cross_score(ha, right_s)} + {1'b0, cross_score(va, s1_below_q)};
    is_edge = s1_active_q && (total > {1'b0, thresh_q});
    result.edge_value = is_edge ? zced_pkg::EDGE_ON : zced_pkg::EDGE_OFF;
    result.out_row    = s1_row_q;
    result.out_col    = s1_col_q;
  end

  zced_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (result),
    .status_o    (q_status),
    .out_o       (out_o)
  );

  `ZCED_ASSERT(a_no_queue_overflow, s1_valid_q |-> !q_status.full, clk_i, rst_ni)
  `ZCED_ASSERT(a_edge_code, out_o.valid |-> (out_o.edge_value == zced_pkg::EDGE_ON || out_o.edge_value == zced_pkg::EDGE_OFF), clk_i, rst_ni)
  `ZCED_ASSERT(a_col_in_frame, (in_accept && !cfg_we_i) |=> (col_ext < width_eff), clk_i, rst_ni)
  `ZCED_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!s1_valid_q && !out_o.valid), clk_i)

endmodule
